// ===== sv/rotated_sprite_alpha_composite_macros.svh =====
// Assertion macros shared by the sprite compositor RTL.
`ifndef ROTATED_SPRITE_ALPHA_COMPOSITE_MACROS_SVH
`define ROTATED_SPRITE_ALPHA_COMPOSITE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RSAC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RSAC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rsac_pkg.sv =====
// Constants, register codes and types for the rotated sprite compositor.
package rsac_pkg;

    // Texture store geometry
    localparam int TEX_W     = 32;
    localparam int TEX_H     = 32;
    localparam int TEX_DEPTH = TEX_W * TEX_H;
    localparam int TEX_AW    = $clog2(TEX_DEPTH);
    localparam int TEX_XW    = $clog2(TEX_W);
    localparam int TEX_YW    = $clog2(TEX_H);

    // Load index field and the width needed to range-check it
    localparam int IDX_W  = 10;
    localparam int TEX_CW = ((TEX_AW > IDX_W) ? TEX_AW : IDX_W) + 1;

    // Texture coordinate arithmetic: Q26 sum, 54 bits signed
    localparam int COORD_W    = 54;
    localparam int COORD_FRAC = 26;
    localparam logic [COORD_W-1:0] TEX_HALF = COORD_W'(TEX_W) << (COORD_FRAC - 1);

    // Stream payload widths
    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 24;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COS_Q14      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIN_Q14      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SCALE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_EXTENT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PHOTO_WIDTH  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PHOTO_HEIGHT = 3'd7;

    // Opcodes carried in s_tuser
    localparam logic OP_LOAD      = 1'b0;
    localparam logic OP_COMPOSITE = 1'b1;

    // Alpha codes with special meaning
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // Inverse scale used when the register holds zero (unity scale)
    localparam logic [19:0] INV_SCALE_ONE = 20'd4096;

    // Item payload travelling down the front of the pipeline
    typedef struct packed {
        logic              op;
        logic              wr_ok;
        logic [TEX_AW-1:0] idx;
        logic [31:0]       tex;    // r, g, b, a from the low byte up
        logic [23:0]       photo;  // r, g, b from the low byte up
    } item_t;

endpackage

// ===== sv/rotated_sprite_alpha_composite.sv =====
// Rotated, scaled sprite composited over photo pixels with alpha blending.
// Throughput: one item per cycle unless m_tready stalls the result stream; set by
// the single texture memory access in stage 7.
// Loads give no result and leave the pipeline at the texture memory stage.
// Reset: configuration returns to defaults and all valid bits clear.
// The texture store is not cleared by reset and holds undefined data until loaded.
`include "rotated_sprite_alpha_composite_macros.svh"

module rotated_sprite_alpha_composite
(
    input  logic                              clk,
    input  logic                              rst_n,
    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // texel_index[9:0], texel_red[17:10], texel_green[25:18], texel_blue[33:26],
    // texel_alpha[41:34], pixel_x[53:42], pixel_y[65:54], photo_red[73:66],
    // photo_green[81:74], photo_blue[89:82], zero[95:90]
    input  logic [rsac_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tuser,   // opcode[0]
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_red[7:0], out_green[15:8], out_blue[23:16]
    output logic [rsac_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tuser,   // covered[0]
    // Configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rsac_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rsac_pkg::CFG_DATA_W-1:0]   cfg_data
);

    typedef enum logic [1:0] {MODE_KEEP, MODE_FULL, MODE_BLEND} mode_t;

    // Configuration registers
    logic signed [13:0] center_x_reg;
    logic signed [13:0] center_y_reg;
    logic signed [15:0] cos_reg;
    logic signed [15:0] sin_reg;
    logic        [19:0] inv_scale_reg;
    logic        [12:0] half_extent_reg;
    logic        [12:0] photo_width_reg;
    logic        [12:0] photo_height_reg;

    // Pipeline control
    logic [8:1] vld_reg;
    logic [9:1] adv;
    logic [6:1] pass_reg;
    rsac_pkg::item_t pay_reg [1:6];

    // Stage 1: offsets from the centre
    logic signed [14:0] s1_dx_reg, s1_dy_reg;
    logic signed [14:0] dx_next, dy_next;
    logic               inb_next;
    logic [rsac_pkg::TEX_CW-1:0] idx_ext;
    rsac_pkg::item_t    item_next;

    // Stage 2: rotation products
    logic signed [30:0] s2_pcx_reg, s2_psy_reg, s2_psx_reg, s2_pcy_reg;
    logic        [12:0] half_eff;
    logic        [13:0] box;
    logic signed [15:0] box_s, dx_s, dy_s;
    logic               box_ok;

    // Stage 3: rotated offsets, Q14
    logic signed [31:0] s3_rx_reg, s3_ry_reg;

    // Stage 4: scaled offsets, Q26
    logic signed [52:0] s4_mx_reg, s4_my_reg;
    logic        [19:0] inv_eff;

    // Stage 5: texture coordinates
    logic [rsac_pkg::TEX_XW-1:0] s5_sx_reg, sx_next;
    logic [rsac_pkg::TEX_YW-1:0] s5_sy_reg, sy_next;
    logic [rsac_pkg::COORD_W-1:0] tx, ty;
    logic [rsac_pkg::COORD_W-rsac_pkg::COORD_FRAC-1:0] hx, hy;
    logic               cx_ok, cy_ok;

    // Stage 6: texture address
    logic [rsac_pkg::TEX_AW-1:0] s6_addr_reg;

    // Stage 7: texture read
    logic [31:0] tex_mem [rsac_pkg::TEX_DEPTH];
    logic [31:0] s7_tex_reg;
    logic [23:0] s7_photo_reg;
    logic        s7_pass_reg;
    logic [7:0]  alpha;

    // Stage 8: blend products
    mode_t       s8_mode_reg;
    logic [23:0] s8_tex_reg, s8_photo_reg;
    logic [15:0] s8_pt_reg [3];
    logic [15:0] s8_pp_reg [3];

    // Output register
    logic                            out_valid_reg;
    logic [rsac_pkg::M_TDATA_W-1:0]  out_data_reg, out_data_next;
    logic                            out_cov_reg, out_cov_next;
    logic [15:0]                     blend_sum;

    //------------------------------------------------------------------
    // Configuration port: always ready, writes land directly
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg     <= '0;
            center_y_reg     <= '0;
            cos_reg          <= 16'sd16384;
            sin_reg          <= '0;
            inv_scale_reg    <= rsac_pkg::INV_SCALE_ONE;
            half_extent_reg  <= 13'd16;
            photo_width_reg  <= 13'd400;
            photo_height_reg <= 13'd240;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                rsac_pkg::REG_CENTER_X:     center_x_reg     <= cfg_data[13:0];
                rsac_pkg::REG_CENTER_Y:     center_y_reg     <= cfg_data[13:0];
                rsac_pkg::REG_COS_Q14:      cos_reg          <= cfg_data[15:0];
                rsac_pkg::REG_SIN_Q14:      sin_reg          <= cfg_data[15:0];
                rsac_pkg::REG_INV_SCALE:    inv_scale_reg    <= cfg_data[19:0];
                rsac_pkg::REG_HALF_EXTENT:  half_extent_reg  <= cfg_data[12:0];
                rsac_pkg::REG_PHOTO_WIDTH:  photo_width_reg  <= cfg_data[12:0];
                rsac_pkg::REG_PHOTO_HEIGHT: photo_height_reg <= cfg_data[12:0];
                default:
                begin
                end
            endcase
        end
    end

    //------------------------------------------------------------------
    // Stage advance: a stage moves when empty or when the next one moves
    always_comb
    begin
        adv[9] = !out_valid_reg || m_tready;
        for (int k = 8; k >= 1; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign s_tready = adv[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv[1]) vld_reg[1] <= s_tvalid;
            for (int k = 2; k <= 8; k++)
            begin
                if (adv[k])
                begin
                    // loads are retired at the memory stage
                    if (k == 7) vld_reg[k] <= vld_reg[6] && pay_reg[6].op;
                    else        vld_reg[k] <= vld_reg[k-1];
                end
            end
            if (adv[9]) out_valid_reg <= vld_reg[8];
        end
    end

    //------------------------------------------------------------------
    // Stage 1: unpack, photo bounds, centre offsets
    always_comb
    begin
        idx_ext         = rsac_pkg::TEX_CW'(s_tdata[9:0]);
        item_next.op    = s_tuser;
        item_next.wr_ok = idx_ext < rsac_pkg::TEX_CW'(rsac_pkg::TEX_DEPTH);
        item_next.idx   = rsac_pkg::TEX_AW'(idx_ext);
        item_next.tex   = s_tdata[41:10];
        item_next.photo = s_tdata[89:66];
        inb_next = ({1'b0, s_tdata[53:42]} < photo_width_reg)
                && ({1'b0, s_tdata[65:54]} < photo_height_reg);
        dx_next  = $signed({3'b000, s_tdata[53:42]})
                 - $signed({center_x_reg[13], center_x_reg});
        dy_next  = $signed({3'b000, s_tdata[65:54]})
                 - $signed({center_y_reg[13], center_y_reg});
    end

    // Stage 2: box around the centre
    always_comb
    begin
        half_eff = (half_extent_reg == '0) ? 13'd1 : half_extent_reg;
        box      = {1'b0, half_eff} + 14'd1;
        box_s    = $signed({2'b00, box});
        dx_s     = {s1_dx_reg[14], s1_dx_reg};
        dy_s     = {s1_dy_reg[14], s1_dy_reg};
        box_ok   = (dx_s <= box_s) && (dx_s >= -box_s)
                && (dy_s <= box_s) && (dy_s >= -box_s);
    end

    // Stage 4: inverse scale, zero means unity
    assign inv_eff = (inv_scale_reg == '0) ? rsac_pkg::INV_SCALE_ONE : inv_scale_reg;

    // Stage 5: add half the texture width, truncate toward zero, range check
    always_comb
    begin
        tx = {s4_mx_reg[52], s4_mx_reg} + rsac_pkg::TEX_HALF;
        ty = {s4_my_reg[52], s4_my_reg} + rsac_pkg::TEX_HALF;
        hx = tx[rsac_pkg::COORD_W-1:rsac_pkg::COORD_FRAC];
        hy = ty[rsac_pkg::COORD_W-1:rsac_pkg::COORD_FRAC];
        // small negative values truncate to texel 0
        cx_ok = tx[rsac_pkg::COORD_W-1]
              ? ((&hx) && (|tx[rsac_pkg::COORD_FRAC-1:0]))
              : (hx < $bits(hx)'(rsac_pkg::TEX_W));
        cy_ok = ty[rsac_pkg::COORD_W-1]
              ? ((&hy) && (|ty[rsac_pkg::COORD_FRAC-1:0]))
              : (hy < $bits(hy)'(rsac_pkg::TEX_H));
        sx_next = tx[rsac_pkg::COORD_W-1] ? '0 : hx[rsac_pkg::TEX_XW-1:0];
        sy_next = ty[rsac_pkg::COORD_W-1] ? '0 : hy[rsac_pkg::TEX_YW-1:0];
    end

    // Datapath registers of stages 1 to 6
    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            pay_reg[1]  <= item_next;
            pass_reg[1] <= inb_next;
            s1_dx_reg   <= dx_next;
            s1_dy_reg   <= dy_next;
        end
        if (adv[2])
        begin
            pay_reg[2]  <= pay_reg[1];
            pass_reg[2] <= pass_reg[1] && box_ok;
            s2_pcx_reg  <= cos_reg * s1_dx_reg;
            s2_psy_reg  <= sin_reg * s1_dy_reg;
            s2_psx_reg  <= sin_reg * s1_dx_reg;
            s2_pcy_reg  <= cos_reg * s1_dy_reg;
        end
        if (adv[3])
        begin
            pay_reg[3]  <= pay_reg[2];
            pass_reg[3] <= pass_reg[2];
            s3_rx_reg   <= {s2_pcx_reg[30], s2_pcx_reg} - {s2_psy_reg[30], s2_psy_reg};
            s3_ry_reg   <= {s2_psx_reg[30], s2_psx_reg} + {s2_pcy_reg[30], s2_pcy_reg};
        end
        if (adv[4])
        begin
            pay_reg[4]  <= pay_reg[3];
            pass_reg[4] <= pass_reg[3];
            s4_mx_reg   <= s3_rx_reg * $signed({1'b0, inv_eff});
            s4_my_reg   <= s3_ry_reg * $signed({1'b0, inv_eff});
        end
        if (adv[5])
        begin
            pay_reg[5]  <= pay_reg[4];
            pass_reg[5] <= pass_reg[4] && cx_ok && cy_ok;
            s5_sx_reg   <= sx_next;
            s5_sy_reg   <= sy_next;
        end
        if (adv[6])
        begin
            pay_reg[6]  <= pay_reg[5];
            pass_reg[6] <= pass_reg[5];
            if (pay_reg[5].op == rsac_pkg::OP_LOAD)
                s6_addr_reg <= pay_reg[5].idx;
            else
                s6_addr_reg <= rsac_pkg::TEX_AW'(s5_sy_reg) * rsac_pkg::TEX_AW'(rsac_pkg::TEX_W)
                             + rsac_pkg::TEX_AW'(s5_sx_reg);
        end
    end

    //------------------------------------------------------------------
    // Stage 7: texture store, one access per cycle (load writes, composite reads)
    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            if (vld_reg[6] && (pay_reg[6].op == rsac_pkg::OP_LOAD) && pay_reg[6].wr_ok)
                tex_mem[s6_addr_reg] <= pay_reg[6].tex;
            s7_tex_reg   <= tex_mem[s6_addr_reg];
            s7_photo_reg <= pay_reg[6].photo;
            s7_pass_reg  <= pass_reg[6];
        end
    end

    // Stage 8: alpha decision and blend products
    assign alpha = s7_tex_reg[31:24];

    always_ff @(posedge clk)
    begin
        if (adv[8])
        begin
            if (!s7_pass_reg || (alpha == rsac_pkg::ALPHA_CLEAR))
                s8_mode_reg <= MODE_KEEP;
            else if (alpha == rsac_pkg::ALPHA_OPAQUE)
                s8_mode_reg <= MODE_FULL;
            else
                s8_mode_reg <= MODE_BLEND;
            s8_tex_reg   <= s7_tex_reg[23:0];
            s8_photo_reg <= s7_photo_reg;
            for (int i = 0; i < 3; i++)
            begin
                s8_pt_reg[i] <= {8'h00, s7_tex_reg[8*i +: 8]} * {8'h00, alpha};
                s8_pp_reg[i] <= {8'h00, s7_photo_reg[8*i +: 8]}
                              * {8'h00, rsac_pkg::ALPHA_OPAQUE - alpha};
            end
        end
    end

    //------------------------------------------------------------------
    // Output register: select and finish the blend
    always_comb
    begin
        blend_sum     = '0;
        out_data_next = s8_photo_reg;
        out_cov_next  = 1'b0;
        case (s8_mode_reg)
            MODE_KEEP:
            begin
                out_data_next = s8_photo_reg;
                out_cov_next  = 1'b0;
            end
            MODE_FULL:
            begin
                out_data_next = s8_tex_reg;
                out_cov_next  = 1'b1;
            end
            MODE_BLEND:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    blend_sum = s8_pt_reg[i] + s8_pp_reg[i];
                    out_data_next[8*i +: 8] = blend_sum[15:8];
                end
                out_cov_next = 1'b1;
            end
            default:
            begin
                out_data_next = s8_photo_reg;
                out_cov_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv[9])
        begin
            out_data_reg <= out_data_next;
            out_cov_reg  <= out_cov_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_cov_reg;

    //------------------------------------------------------------------
    // Checks
    `RSAC_ASSERT_NEXT(a_load_retired, adv[7] && vld_reg[6] && (pay_reg[6].op == rsac_pkg::OP_LOAD), !vld_reg[7], "load reached the result stages")
    `RSAC_ASSERT_SAME(a_full_stalls_input, m_tvalid && !m_tready && (&vld_reg), !s_tready, "input taken with a full stalled pipeline")
    `RSAC_ASSERT_NEXT(a_bounds_fail_kept, adv[2] && vld_reg[1] && !pass_reg[1], !pass_reg[2], "out of bounds pixel passed the box stage")
    `RSAC_ASSERT_NEXT(a_uncovered_keep, adv[8] && vld_reg[7] && !s7_pass_reg, s8_mode_reg == MODE_KEEP, "rejected pixel not passed through")

endmodule

// ===== sim/sprite_composite_checker.sv =====
// Stream checker for the rotated sprite compositor: predicts each composite and compares it.
module sprite_composite_checker
    import rsac_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  m_tuser,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    pending,
    output int                    results_checked,
    output int                    covered_seen
);

    localparam longint Q26_ONE    = longint'(1) <<< 26;
    localparam longint TEX_CENTRE = longint'(TEX_W) <<< 25;   // half the texture width in Q26

    typedef struct packed {
        logic       covered;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_out_t;

    // Shadow of the register file
    logic signed [13:0] centre_x;
    logic signed [13:0] centre_y;
    logic signed [15:0] cos_q14;
    logic signed [15:0] sin_q14;
    logic [19:0]        inv_scale;
    logic [12:0]        half_extent;
    logic [12:0]        photo_w;
    logic [12:0]        photo_h;

    // Texel shadow: alpha, blue, green, red from the top byte down
    logic [31:0] texels [TEX_DEPTH];

    // Composites accepted whose result has not yet been seen
    pixel_out_t awaited_pixels [$];

    function automatic logic [7:0] mix(input logic [7:0] fg, input logic [7:0] bg,
                                       input logic [7:0] a);
        int sum;
        sum = int'(fg) * int'(a) + int'(bg) * (255 - int'(a));
        return 8'(sum >>> 8);
    endfunction

    // Expected colour of one photo pixel under the current setting
    function automatic pixel_out_t composite_pixel(input logic [11:0] px, input logic [11:0] py,
                                                   input logic [7:0] pr, input logic [7:0] pg,
                                                   input logic [7:0] pb);
        pixel_out_t res;
        longint     box;
        longint     dx;
        longint     dy;
        longint     inv;
        longint     rx;
        longint     ry;
        longint     col;
        longint     row;
        logic [31:0] texel;
        logic [7:0]  alpha;
        res.red     = pr;
        res.green   = pg;
        res.blue    = pb;
        res.covered = 1'b0;

        // photo bounds
        if ({1'b0, px} >= photo_w || {1'b0, py} >= photo_h)
            return res;

        // square box around the centre, zero half extent counts as one
        box = (half_extent == '0) ? 2 : longint'(half_extent) + 1;
        dx  = longint'(px) - longint'(centre_x);
        dy  = longint'(py) - longint'(centre_y);
        if (dx < -box || dx > box || dy < -box || dy > box)
            return res;

        // inverse rotation and scaling, Q14 * Q12 = Q26, truncated toward zero
        inv = (inv_scale == '0) ? longint'(INV_SCALE_ONE) : longint'(inv_scale);
        rx  = longint'(cos_q14) * dx - longint'(sin_q14) * dy;
        ry  = longint'(sin_q14) * dx + longint'(cos_q14) * dy;
        col = (rx * inv + TEX_CENTRE) / Q26_ONE;
        row = (ry * inv + TEX_CENTRE) / Q26_ONE;
        if (col < 0 || col >= TEX_W || row < 0 || row >= TEX_H)
            return res;

        texel = texels[row * TEX_W + col];
        alpha = texel[31:24];
        if (alpha == ALPHA_CLEAR)
            return res;
        if (alpha == ALPHA_OPAQUE)
        begin
            res.red   = texel[7:0];
            res.green = texel[15:8];
            res.blue  = texel[23:16];
        end
        else
        begin
            res.red   = mix(texel[7:0], pr, alpha);
            res.green = mix(texel[15:8], pg, alpha);
            res.blue  = mix(texel[23:16], pb, alpha);
        end
        res.covered = 1'b1;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_out_t want;
        pixel_out_t got;
        logic       bad;
        if (!rst_n)
        begin
            centre_x        <= '0;
            centre_y        <= '0;
            cos_q14         <= 16'sd16384;
            sin_q14         <= '0;
            inv_scale       <= 20'd4096;
            half_extent     <= 13'd16;
            photo_w         <= 13'd400;
            photo_h         <= 13'd240;
            awaited_pixels.delete();
            mismatches      <= 0;
            pending         <= 0;
            results_checked <= 0;
            covered_seen    <= 0;
        end
        else
        begin
            // register write transfers
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_CENTER_X:     centre_x    <= cfg_data[13:0];
                    REG_CENTER_Y:     centre_y    <= cfg_data[13:0];
                    REG_COS_Q14:      cos_q14     <= cfg_data[15:0];
                    REG_SIN_Q14:      sin_q14     <= cfg_data[15:0];
                    REG_INV_SCALE:    inv_scale   <= cfg_data[19:0];
                    REG_HALF_EXTENT:  half_extent <= cfg_data[12:0];
                    REG_PHOTO_WIDTH:  photo_w     <= cfg_data[12:0];
                    REG_PHOTO_HEIGHT: photo_h     <= cfg_data[12:0];
                    default: ;
                endcase
            end

            // result transfers, checked against the oldest outstanding pixel
            if (m_tvalid && m_tready)
            begin
                got.red     = m_tdata[7:0];
                got.green   = m_tdata[15:8];
                got.blue    = m_tdata[23:16];
                got.covered = m_tuser;
                results_checked <= results_checked + 1;
                if (got.covered === 1'b1)
                    covered_seen <= covered_seen + 1;
                if (awaited_pixels.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual rgb %h %h %h covered %b",
                             $time, got.red, got.green, got.blue, got.covered);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = awaited_pixels.pop_front();
                    bad  = 1'b0;
                    if (got.red !== want.red)
                    begin
                        $display("%0t: out_red mismatch, expected %0d, actual %0d",
                                 $time, want.red, got.red);
                        bad = 1'b1;
                    end
                    if (got.green !== want.green)
                    begin
                        $display("%0t: out_green mismatch, expected %0d, actual %0d",
                                 $time, want.green, got.green);
                        bad = 1'b1;
                    end
                    if (got.blue !== want.blue)
                    begin
                        $display("%0t: out_blue mismatch, expected %0d, actual %0d",
                                 $time, want.blue, got.blue);
                        bad = 1'b1;
                    end
                    if (got.covered !== want.covered)
                    begin
                        $display("%0t: covered mismatch, expected %b, actual %b",
                                 $time, want.covered, got.covered);
                        bad = 1'b1;
                    end
                    if (bad)
                        mismatches <= mismatches + 1;
                end
            end

            // input transfers: loads update the texel shadow, composites queue a prediction
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == OP_LOAD)
                begin
                    if (int'(s_tdata[9:0]) < TEX_DEPTH)
                        texels[s_tdata[9:0]] <= {s_tdata[41:34], s_tdata[33:26],
                                                 s_tdata[25:18], s_tdata[17:10]};
                end
                else
                    awaited_pixels.push_back(composite_pixel(s_tdata[53:42], s_tdata[65:54],
                                                             s_tdata[73:66], s_tdata[81:74],
                                                             s_tdata[89:82]));
            end
            pending <= awaited_pixels.size();
        end
    end

endmodule

// ===== sim/rotated_sprite_alpha_composite_test.sv =====
// Testbench top for the rotated sprite compositor: clock, reset, stimulus and verdict.
module rotated_sprite_alpha_composite_test;
    import rsac_pkg::*;

    localparam int CYCLE_LIMIT     = 500000;
    localparam int RANDOM_ITEMS    = 53;   // random items per register setting
    localparam int SETUPS          = 10;
    localparam int NEAR_ZERO_SETUP = 2;    // setting where texture coordinates dip just below zero
    localparam int SETTLE_CYCLES   = 12;   // covers the result latency and loads still in flight
    localparam int BODY_W          = 90;
    localparam int PIXEL_MAX       = 4095;
    localparam int CENTRE_TEXEL    = (TEX_H / 2) * TEX_W + TEX_W / 2;

    typedef struct packed {
        int cx;
        int cy;
        int cos_q;
        int sin_q;
        int inv;
        int half;
        int w;
        int h;
    } sprite_setup_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = OP_LOAD;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_CENTER_X;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int mismatches;
    int pending;
    int results_checked;
    int covered_seen;
    int cycles          = 0;
    int loads_sent      = 0;
    int composites_sent = 0;

    bit src_gaps_on   = 1'b0;
    bit dst_stalls_on = 1'b0;

    // Texels written so far; a composite never reads one that is not
    bit texel_loaded [TEX_DEPTH];

    sprite_setup_t setups [SETUPS];
    sprite_setup_t live;   // setting the block currently holds

    rotated_sprite_alpha_composite DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sprite_composite_checker pixel_check
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .pending         (pending),
        .results_checked (results_checked),
        .covered_seen    (covered_seen)
    );

    // Clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles, %0d results outstanding", cycles, pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side: random stall before each transfer
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = dst_stalls_on ? $urandom_range(0, 12) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (m_tvalid !== 1'b1)
                @(posedge clk);
        end
    end

    function automatic logic [7:0] pick_alpha();
        case ($urandom_range(0, 3))
            0:       return ALPHA_CLEAR;
            1:       return ALPHA_OPAQUE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Texel a pixel reads under the live setting, -1 when an earlier test rejects it
    function automatic int texel_reached(input int x, input int y);
        longint box;
        longint dx;
        longint dy;
        longint inv;
        longint col;
        longint row;
        if (x >= live.w || y >= live.h)
            return -1;
        box = (live.half == 0) ? 2 : longint'(live.half) + 1;
        dx  = longint'(x) - longint'(live.cx);
        dy  = longint'(y) - longint'(live.cy);
        if (dx < -box || dx > box || dy < -box || dy > box)
            return -1;
        inv = (live.inv == 0) ? longint'(INV_SCALE_ONE) : longint'(live.inv);
        col = ((longint'(live.cos_q) * dx - longint'(live.sin_q) * dy) * inv
              + (longint'(TEX_W) <<< 25)) / (longint'(1) <<< 26);
        row = ((longint'(live.sin_q) * dx + longint'(live.cos_q) * dy) * inv
              + (longint'(TEX_W) <<< 25)) / (longint'(1) <<< 26);
        if (col < 0 || col >= TEX_W || row < 0 || row >= TEX_H)
            return -1;
        return int'(row) * TEX_W + int'(col);
    endfunction

    // One input transfer after a random gap
    task automatic push_item(input logic op, input logic [BODY_W-1:0] body);
        int gap;
        gap = src_gaps_on ? $urandom_range(0, 12) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_TDATA_W'(body);
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
    endtask

    // Photo fields of a load carry noise, the block must ignore them
    task automatic load_texel(input logic [9:0] idx, input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b, input logic [7:0] a);
        logic [63:0] noise;
        noise = {$urandom, $urandom};
        push_item(OP_LOAD, {noise[47:0], a, b, g, r, idx});
        texel_loaded[idx] = 1'b1;
        loads_sent++;
    endtask

    // Texel fields of a composite carry noise as well
    task automatic composite(input int x, input int y, input logic [7:0] r,
                             input logic [7:0] g, input logic [7:0] b);
        logic [63:0] noise;
        int          texel;
        // a texel not yet written gets a random one before the pixel reads it
        texel = texel_reached(x, y);
        if (texel >= 0 && !texel_loaded[texel])
            load_texel(10'(texel), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), pick_alpha());
        noise = {$urandom, $urandom};
        push_item(OP_COMPOSITE, {b, g, r, 12'(y), 12'(x), noise[41:0]});
        composites_sent++;
    endtask

    // Pixel mostly near the sticker centre so the deeper tests are reached
    task automatic random_composite();
        int box;
        int reach;
        int x;
        int y;
        box   = (live.half == 0 ? 1 : live.half) + 1;
        reach = (box + 3 > 40) ? 40 : box + 3;
        x = live.cx + int'($urandom_range(0, 2 * reach)) - reach;
        y = live.cy + int'($urandom_range(0, 2 * reach)) - reach;
        if ($urandom_range(0, 3) == 0 || x < 0 || x > PIXEL_MAX)
            x = $urandom_range(0, PIXEL_MAX);
        if ($urandom_range(0, 3) == 0 || y < 0 || y > PIXEL_MAX)
            y = $urandom_range(0, PIXEL_MAX);
        composite(x, y, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
    endtask

    task automatic random_burst();
        int n;
        int start;
        n     = 0;
        start = loads_sent + composites_sent;
        while (loads_sent + composites_sent - start < RANDOM_ITEMS)
        begin
            if (n % 16 == 0)
            begin
                src_gaps_on   = ($urandom_range(0, 2) != 0);
                dst_stalls_on = ($urandom_range(0, 2) != 0);
            end
            if ($urandom_range(0, 4) == 0)
                load_texel(10'($urandom_range(0, TEX_DEPTH - 1)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           pick_alpha());
            else
                random_composite();
            n++;
        end
    endtask

    // Wait until every result is back and loads have left the pipeline
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
    endtask

    task automatic apply_setup(input sprite_setup_t s);
        write_reg(REG_CENTER_X, s.cx);
        write_reg(REG_CENTER_Y, s.cy);
        write_reg(REG_COS_Q14, s.cos_q);
        write_reg(REG_SIN_Q14, s.sin_q);
        write_reg(REG_INV_SCALE, s.inv);
        write_reg(REG_HALF_EXTENT, s.half);
        write_reg(REG_PHOTO_WIDTH, s.w);
        write_reg(REG_PHOTO_HEIGHT, s.h);
        cfg_valid <= 1'b0;
        live = s;
    endtask

    initial
    begin
        int k;
        live = '{0, 0, 16384, 0, 4096, 16, 400, 240};
        setups[0] = '{100, 80, 0, 16384, 4096, 16, 400, 240};                // quarter turn
        setups[1] = '{200, 120, 11585, 11585, 2048, 40, 640, 480};           // eighth turn, x2
        setups[2] = '{100, 100, 16384, 0, 4095, 16, 400, 240};               // just under unity
        setups[3] = '{-4096, 8191, -16384, 16384, 1048575, 4096, 4096, 4096};
        setups[4] = '{2000, 3000, 16384, -16384, 1, 4096, 4096, 4096};
        setups[5] = '{5, 5, -16384, 0, 0, 0, 8191, 8191};                    // zero scale, extent
        setups[6] = '{8191, -8192, 16384, 0, 4096, 8191, 0, 240};            // zero width
        setups[7] = '{30, 30, 16384, 0, 4096, 16, 400, 0};                   // zero height
        setups[8] = '{60, 60, 32767, -32768, 1024, 20, 400, 240};
        setups[9] = '{50, 60, 14189, 8192, 3000, 24, 400, 240};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting: unity scale, centre at the origin, box of 17
        load_texel(10'(CENTRE_TEXEL), 8'd255, 8'd0, 8'd128, ALPHA_OPAQUE);
        composite(0, 0, 8'd0, 8'd255, 8'd0);                  // opaque texel replaces
        load_texel(10'(CENTRE_TEXEL), 8'd9, 8'd9, 8'd9, ALPHA_CLEAR);
        composite(0, 0, 8'd12, 8'd34, 8'd56);                 // clear texel passes through
        load_texel(10'(CENTRE_TEXEL), 8'd255, 8'd255, 8'd255, 8'd1);
        composite(0, 0, 8'd0, 8'd0, 8'd0);                    // faintest blend
        load_texel(10'(CENTRE_TEXEL), 8'd0, 8'd0, 8'd0, 8'd254);
        composite(0, 0, 8'd255, 8'd255, 8'd255);              // strongest blend
        composite(399, 239, 8'd255, 8'd255, 8'd255);          // last photo pixel, outside box
        composite(400, 0, 8'd1, 8'd2, 8'd3);                  // just past photo width
        composite(0, 240, 8'd4, 8'd5, 8'd6);                  // just past photo height
        composite(PIXEL_MAX, PIXEL_MAX, 8'd7, 8'd8, 8'd9);
        load_texel(10'(TEX_DEPTH - 1), 8'd17, 8'd34, 8'd51, ALPHA_OPAQUE);
        composite(15, 15, 8'd0, 8'd0, 8'd0);                  // last texel of the texture
        composite(16, 0, 8'd0, 8'd0, 8'd0);                   // first column past the texture
        composite(17, 0, 8'd0, 8'd0, 8'd0);                   // box edge, outside texture
        composite(18, 0, 8'd0, 8'd0, 8'd0);                   // just outside the box
        composite(0, 17, 8'd0, 8'd0, 8'd0);
        random_burst();

        for (k = 0; k < SETUPS; k++)
        begin
            drain();
            apply_setup(setups[k]);
            // coordinates just below zero truncate onto texel zero
            if (k == NEAR_ZERO_SETUP)
            begin
                composite(83, 100, 8'd20, 8'd40, 8'd60);
                composite(100, 83, 8'd20, 8'd40, 8'd60);
                composite(83, 83, 8'd20, 8'd40, 8'd60);
            end
            random_burst();
        end
        drain();

        $display("Sent %0d texel loads and %0d pixel composites over %0d register settings.",
                 loads_sent, composites_sent, SETUPS + 1);
        $display("Compared %0d results, %0d of them changed by the sprite.",
                 results_checked, covered_seen);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
